// File: rtl/hgrc_pkg.sv
package hgrc_pkg;

  // Largest frame the position counters cover.
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;

  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned SIZE_W      = 12;
  localparam int unsigned COUNT_W     = 22;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_DATA_W  = 22;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

  // Register reset values.
  localparam int unsigned RST_WIDTH     = 640;
  localparam int unsigned RST_HEIGHT    = 480;
  localparam int unsigned RST_THRESHOLD = 40000;
  localparam int unsigned RST_SAT_MAX   = 105;
  localparam int unsigned RST_VAL_MIN   = 80;
  localparam int unsigned RST_VAL_MAX   = 230;
  localparam int unsigned RST_REGION    = RST_HEIGHT * 7 / 10;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH     = CFG_INDEX_W'(0),
    REG_FRAME_HEIGHT    = CFG_INDEX_W'(1),
    REG_COUNT_THRESHOLD = CFG_INDEX_W'(2),
    REG_SAT_MAX         = CFG_INDEX_W'(3),
    REG_VAL_MIN         = CFG_INDEX_W'(4),
    REG_VAL_MAX         = CFG_INDEX_W'(5)
  } cfg_reg_e;

  // Configuration as the datapath sees it, sizes already clamped.
  typedef struct packed {
    logic [COL_W-1:0]   width_last;
    logic [ROW_W-1:0]   height_last;
    logic [ROW_W-1:0]   region_start;
    logic [COUNT_W-1:0] count_threshold;
    logic [PIX_W-1:0]   sat_max;
    logic [PIX_W-1:0]   val_min;
    logic [PIX_W-1:0]   val_max;
  } cfg_t;

  // Classified pixel handed to the counter stage.
  typedef struct packed {
    logic grey;
    logic frame_start;
  } grey_word_t;

endpackage

// File: rtl/hsv_gray_region_pixel_counter.sv
// Grey region pixel counter. Takes one BGR pixel word per clock in raster
// order and, at the last pixel of each frame, returns one result word with
// the number of grey pixels seen in the lower 30 percent of the frame and a
// flag that is set when that number exceeds count_threshold. A pixel is
// grey when its brightness max(B,G,R) lies within val_min..val_max and its
// saturation is at most sat_max. frame_start on a pixel makes it the first
// of a new frame; without it the block simply counts width x height pixels
// per frame. The pipeline has an input register, a classification register
// and the result register, which a pixel passes in that order. It sustains
// one pixel per cycle; the only stall is a result word held in the result
// register while out_ready_i is low, which halts the whole three-stage
// pipeline. Configuration words are taken every cycle and must only be
// written while no pixel is in flight; the height register also sets the
// start row of the counted region.
module hsv_gray_region_pixel_counter import hgrc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PIX_W-1:0]       blue_i,
  input  logic [PIX_W-1:0]       green_i,
  input  logic [PIX_W-1:0]       red_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   grey_found_o,
  output logic [COUNT_W-1:0]     grey_total_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t       cfg;
  logic       advance;
  logic       word_valid;
  grey_word_t word;

  // The pipeline moves whenever the result register is free or drained.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  hgrc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hgrc_grey u_grey (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .in_valid_i    (in_valid_i),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg),
    .word_valid_o  (word_valid),
    .word_o        (word)
  );

  hgrc_count u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .word_valid_i (word_valid),
    .word_i       (word),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .grey_found_o (grey_found_o),
    .grey_total_o (grey_total_o)
  );

endmodule

// File: rtl/hgrc_cfg.sv
module hgrc_cfg import hgrc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output cfg_t                   cfg_o
);

  localparam int unsigned HX_W   = $clog2(MAX_HEIGHT * 7 + 1);
  localparam int unsigned HALF_W = HX_W - 1;
  localparam int unsigned PROD_W = HALF_W + 16;
  // floor(x / 5) = (x * 52429) >> 18 for every x below 2**18.
  localparam int unsigned RECIP5 = 52429;
  localparam int unsigned RECIP5_SHIFT = 18;

  cfg_t cfg_q, cfg_d;

  logic [SIZE_W-1:0] size_wr;
  logic [COL_W-1:0]  width_last;
  logic [ROW_W:0]    height_clamp;
  logic [HX_W-1:0]   height_x7;
  logic [HALF_W-1:0] height_half;
  logic [PROD_W-1:0] region_prod;
  logic [ROW_W-1:0]  region_start;

  assign cfg_ready_o = 1'b1;
  assign size_wr     = cfg_data_i[SIZE_W-1:0];

  // Clamp the written width to 1..MAX_WIDTH and keep the last column.
  always_comb begin
    if (size_wr == '0) begin
      width_last = '0;
    end else if (32'(size_wr) > MAX_WIDTH) begin
      width_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last = COL_W'(size_wr - SIZE_W'(1));
    end
  end

  // Clamp the written height to 1..MAX_HEIGHT.
  always_comb begin
    if (size_wr == '0) begin
      height_clamp = (ROW_W+1)'(1);
    end else if (32'(size_wr) > MAX_HEIGHT) begin
      height_clamp = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      height_clamp = (ROW_W+1)'(size_wr);
    end
  end

  // Region start is floor(height*7/10), taken as floor(floor(7h/2)/5).
  assign height_x7    = HX_W'({height_clamp, 3'b000}) - HX_W'(height_clamp);
  assign height_half  = height_x7[HX_W-1:1];
  assign region_prod  = PROD_W'(height_half) * PROD_W'(RECIP5);
  assign region_start = ROW_W'(region_prod[PROD_W-1:RECIP5_SHIFT]);

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH: begin
          cfg_d.width_last = width_last;
        end
        REG_FRAME_HEIGHT: begin
          cfg_d.height_last  = ROW_W'(height_clamp - (ROW_W+1)'(1));
          cfg_d.region_start = region_start;
        end
        REG_COUNT_THRESHOLD: begin
          cfg_d.count_threshold = cfg_data_i[COUNT_W-1:0];
        end
        REG_SAT_MAX: begin
          cfg_d.sat_max = cfg_data_i[PIX_W-1:0];
        end
        REG_VAL_MIN: begin
          cfg_d.val_min = cfg_data_i[PIX_W-1:0];
        end
        REG_VAL_MAX: begin
          cfg_d.val_max = cfg_data_i[PIX_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_last      <= COL_W'(RST_WIDTH - 1);
      cfg_q.height_last     <= ROW_W'(RST_HEIGHT - 1);
      cfg_q.region_start    <= ROW_W'(RST_REGION);
      cfg_q.count_threshold <= COUNT_W'(RST_THRESHOLD);
      cfg_q.sat_max         <= PIX_W'(RST_SAT_MAX);
      cfg_q.val_min         <= PIX_W'(RST_VAL_MIN);
      cfg_q.val_max         <= PIX_W'(RST_VAL_MAX);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/hgrc_grey.sv
module hgrc_grey import hgrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  logic [PIX_W-1:0] blue_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] red_i,
  input  logic             frame_start_i,
  input  cfg_t             cfg_i,
  output logic             word_valid_o,
  output grey_word_t       word_o
);

  localparam int unsigned CMP_W = 2 * PIX_W + 2;

  logic             in_valid_q;
  logic [PIX_W-1:0] blue_q, green_q, red_q;
  logic             frame_start_q;

  logic [PIX_W-1:0] hi, lo, diff;
  logic [PIX_W:0]   sat_p1;
  logic [CMP_W-1:0] sat_lhs, sat_rhs;
  logic             sat_ok, val_ok;

  logic       word_valid_q;
  grey_word_t word_q, word_d;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en_i) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_i) begin
      blue_q        <= blue_i;
      green_q       <= green_i;
      red_q         <= red_i;
      frame_start_q <= frame_start_i;
    end
  end

  // Brightness is the largest component, the smallest sets saturation.
  always_comb begin
    hi = blue_q;
    lo = blue_q;
    if (green_q > hi) begin
      hi = green_q;
    end
    if (red_q > hi) begin
      hi = red_q;
    end
    if (green_q < lo) begin
      lo = green_q;
    end
    if (red_q < lo) begin
      lo = red_q;
    end
  end

  // Saturation round(255*d/V) <= sat_max is the same as
  // 510*d + V < 2*V*(sat_max+1), so no divider is needed.
  assign diff    = hi - lo;
  assign sat_p1  = (PIX_W+1)'(cfg_i.sat_max) + (PIX_W+1)'(1);
  assign sat_lhs = CMP_W'({diff, 9'b0}) - CMP_W'({diff, 1'b0}) + CMP_W'(hi);
  assign sat_rhs = CMP_W'({hi, 1'b0}) * CMP_W'(sat_p1);
  assign sat_ok  = (hi == '0) || (sat_lhs < sat_rhs);
  assign val_ok  = (hi >= cfg_i.val_min) && (hi <= cfg_i.val_max);

  assign word_d.grey        = sat_ok && val_ok;
  assign word_d.frame_start = frame_start_q;

  // Classification register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (en_i) begin
      word_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_q) begin
      word_q <= word_d;
    end
  end

  assign word_valid_o = word_valid_q;
  assign word_o       = word_q;

endmodule

// File: rtl/hgrc_count.sv
module hgrc_count import hgrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               word_valid_i,
  input  grey_word_t         word_i,
  input  cfg_t               cfg_i,
  output logic               out_valid_o,
  output logic               grey_found_o,
  output logic [COUNT_W-1:0] grey_total_o
);

  logic [COL_W-1:0]   column_q, column_d, column_cur;
  logic [ROW_W-1:0]   row_q, row_d, row_cur;
  logic [COUNT_W-1:0] count_q, count_d, count_cur, count_next;
  logic               count_inc, row_end, frame_end;

  logic               out_valid_q, out_valid_d;
  logic               found_q;
  logic [COUNT_W-1:0] total_q;

  // A frame start clears position and count before the pixel is used.
  assign column_cur = word_i.frame_start ? '0 : column_q;
  assign row_cur    = word_i.frame_start ? '0 : row_q;
  assign count_cur  = word_i.frame_start ? '0 : count_q;

  // Count grey pixels in the lower region, saturating at the top.
  assign count_inc  = word_i.grey && (row_cur >= cfg_i.region_start) &&
                      (count_cur != COUNT_LIMIT);
  assign count_next = count_cur + COUNT_W'(count_inc);

  assign row_end   = column_cur >= cfg_i.width_last;
  assign frame_end = row_end && (row_cur >= cfg_i.height_last);

  // Position and count update.
  always_comb begin
    column_d    = column_q;
    row_d       = row_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (en_i) begin
      out_valid_d = word_valid_i && frame_end;
      if (word_valid_i) begin
        if (frame_end) begin
          column_d = '0;
          row_d    = '0;
          count_d  = '0;
        end else if (row_end) begin
          column_d = '0;
          row_d    = row_cur + ROW_W'(1);
          count_d  = count_next;
        end else begin
          column_d = column_cur + COL_W'(1);
          row_d    = row_cur;
          count_d  = count_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      column_q    <= column_d;
      row_q       <= row_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, loaded at the last pixel of a frame.
  always_ff @(posedge clk_i) begin
    if (en_i && word_valid_i && frame_end) begin
      found_q <= count_next > cfg_i.count_threshold;
      total_q <= count_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign grey_found_o = found_q;
  assign grey_total_o = total_q;

endmodule

// File: rtl/hgrc_checker.sv
module hgrc_checker import hgrc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [PIX_W-1:0]       blue_i,
  input logic [PIX_W-1:0]       green_i,
  input logic [PIX_W-1:0]       red_i,
  input logic                   frame_start_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   grey_found_o,
  input logic [COUNT_W-1:0]     grey_total_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CFG_INDEX_W-1:0] cfg_index_i,
  input logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // A result word waiting on the consumer stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(grey_total_o) && $stable(grey_found_o))
    else $error("result word changed while stalled");

  // Pixels are taken exactly when the result register can move.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow result register state");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result word shown right after reset");

  // An empty count can never exceed the threshold.
  a_zero_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (grey_total_o == '0) |-> !grey_found_o)
    else $error("detection flagged with zero grey pixels");

endmodule

bind hsv_gray_region_pixel_counter hgrc_checker u_checker (.*);
